// ===== hdl/ks_pkg.sv =====
// shared types and constants for the key sort engine
package ks_pkg;

  // default capacity and stored key width
  localparam int unsigned KS_MAX_ITEMS = 64;
  localparam int unsigned KS_KEY_WIDTH = 32;

  // width of the key fields on the ports
  localparam int unsigned KS_IO_WIDTH = 32;

  // input beat: one key of the set
  typedef struct packed {
    logic [KS_IO_WIDTH-1:0] key;
    logic                   last_in;
  } ks_item_t;

  // result beat: one key of the sorted run
  typedef struct packed {
    logic [KS_IO_WIDTH-1:0] sorted_key;
    logic                   last_out;
    logic                   overflow;
  } ks_result_t;

endpackage

// ===== hdl/ks_cmp.sv =====
// shared key comparator: a greater than b in unsigned or two's-complement order
module ks_cmp #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                 signed_i,
  input  logic [KEY_WIDTH-1:0] a_i,
  input  logic [KEY_WIDTH-1:0] b_i,
  output logic                 gt_o
);

  logic [KEY_WIDTH-1:0] flip;
  logic [KEY_WIDTH-1:0] a_ord;
  logic [KEY_WIDTH-1:0] b_ord;

  // flipping the sign bit maps signed order onto unsigned order
  assign flip  = {signed_i, {(KEY_WIDTH-1){1'b0}}};
  assign a_ord = a_i ^ flip;
  assign b_ord = b_i ^ flip;
  assign gt_o  = a_ord > b_ord;

endmodule

// ===== hdl/key_sort_engine.sv =====
// key sort engine: loads a set of keys, insertion sorts them in place, streams them out
// Load: one key per cycle while busy is low; the beat with last_in starts the sort.
// Sort: one shared comparator over a simple dual-port key memory; each key passes FETCH
//   and CUR, then one CMP per shifted entry, then a final CMP or, at entry 0, PLACE.
// Output: after the sort, results come from the registered read port, one result per cycle, n in all;
//   the receiver cannot stall, and busy drops as the final result is shown.
// Reset clears the sequencer, key count, flags and signed_q; the key memory is not cleared.
module key_sort_engine
  import ks_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = KS_MAX_ITEMS,
  parameter int unsigned KEY_WIDTH = KS_KEY_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  ks_item_t   item_i,
  output logic       res_strobe_o,
  output ks_result_t result_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW = $clog2(MAX_ITEMS);

  // sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_CUR   = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        i_q, i_d;
  logic [AW-1:0]        j_q, j_d;
  logic [CW-1:0]        o_q, o_d;
  logic [KEY_WIDTH-1:0] cur_q, cur_d;
  logic                 dropped_q, dropped_d;
  logic                 ovf_q, ovf_d;
  logic                 mode_q, mode_d;
  logic                 signed_q;
  logic                 pend_q, pend_d;
  logic                 lastq_q, lastq_d;

  logic [KEY_WIDTH-1:0] mem [MAX_ITEMS];
  logic [KEY_WIDTH-1:0] rd_q;
  logic [AW-1:0]        ra;
  logic                 we;
  logic [AW-1:0]        wa;
  logic [KEY_WIDTH-1:0] wd;

  logic                 accept;
  logic                 full;
  logic [CW-1:0]        n_new;
  logic [CW-1:0]        i_next;
  logic                 gt;
  logic [KEY_WIDTH-1:0] key_in;
  logic [CW-1:0]        n_last;

  // key narrowing or zero-extension on the way in
  if (KEY_WIDTH <= KS_IO_WIDTH) begin : g_in_narrow
    assign key_in = item_i.key[KEY_WIDTH-1:0];
  end else begin : g_in_wide
    assign key_in = {{(KEY_WIDTH-KS_IO_WIDTH){1'b0}}, item_i.key};
  end

  // key narrowing or zero-extension on the way out
  if (KEY_WIDTH >= KS_IO_WIDTH) begin : g_out_narrow
    assign result_o.sorted_key = rd_q[KS_IO_WIDTH-1:0];
  end else begin : g_out_wide
    assign result_o.sorted_key = {{(KS_IO_WIDTH-KEY_WIDTH){1'b0}}, rd_q};
  end

  assign result_o.last_out = lastq_q;
  assign result_o.overflow = ovf_q;
  assign res_strobe_o      = pend_q;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign full   = (cnt_q == CW'(MAX_ITEMS));
  assign n_new  = full ? cnt_q : cnt_q + CW'(1);
  assign i_next = i_q + CW'(1);
  assign n_last = cnt_q - CW'(1);

  // shared comparator: stored neighbour against the key being inserted
  ks_cmp #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_cmp (
    .signed_i (mode_q),
    .a_i      (rd_q),
    .b_i      (cur_q),
    .gt_o     (gt)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    o_d       = o_q;
    cur_d     = cur_q;
    dropped_d = dropped_q;
    ovf_d     = ovf_q;
    mode_d    = mode_q;
    pend_d    = 1'b0;
    lastq_d   = lastq_q;
    ra        = i_q[AW-1:0];
    we        = 1'b0;
    wa        = cnt_q[AW-1:0];
    wd        = key_in;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!full) begin
            we    = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end else begin
            dropped_d = 1'b1;
          end
          if (item_i.last_in) begin
            ovf_d     = dropped_q || full;
            dropped_d = 1'b0;
            mode_d    = signed_q;
            i_d       = CW'(1);
            o_d       = '0;
            state_d   = (n_new == CW'(1)) ? S_OUT : S_FETCH;
          end
        end
      end
      S_FETCH: begin
        ra      = i_q[AW-1:0];
        state_d = S_CUR;
      end
      S_CUR: begin
        cur_d   = rd_q;
        ra      = AW'(i_q - CW'(1));
        j_d     = i_q[AW-1:0];
        state_d = S_CMP;
      end
      S_CMP: begin
        we = 1'b1;
        wa = j_q;
        if (gt) begin
          // shift the neighbour up and look one further down
          wd  = rd_q;
          j_d = j_q - AW'(1);
          ra  = j_q - AW'(2);
          if (j_q == AW'(1)) begin
            state_d = S_PLACE;
          end
        end else begin
          wd  = cur_q;
          i_d = i_next;
          state_d = (i_next == cnt_q) ? S_OUT : S_FETCH;
        end
      end
      S_PLACE: begin
        we      = 1'b1;
        wa      = '0;
        wd      = cur_q;
        i_d     = i_next;
        state_d = (i_next == cnt_q) ? S_OUT : S_FETCH;
      end
      S_OUT: begin
        // read one entry a cycle, the beat shows on the next cycle
        ra      = o_q[AW-1:0];
        pend_d  = 1'b1;
        lastq_d = (o_q == n_last);
        o_d     = o_q + CW'(1);
        if (o_q == n_last) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      o_q       <= '0;
      dropped_q <= 1'b0;
      ovf_q     <= 1'b0;
      mode_q    <= 1'b0;
      signed_q  <= 1'b0;
      pend_q    <= 1'b0;
      lastq_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      i_q       <= i_d;
      j_q       <= j_d;
      o_q       <= o_d;
      dropped_q <= dropped_d;
      ovf_q     <= ovf_d;
      mode_q    <= mode_d;
      pend_q    <= pend_d;
      lastq_q   <= lastq_d;
      if (cfg_valid_i && cfg_ready_o) begin
        signed_q <= cfg_data_i;
      end
    end
  end

  // key being inserted
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  // key memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

endmodule
